FILE: hdl/fdt_pkg.sv
// Shared types, codes and constants for the structure block token parser.
package fdt_pkg;

   localparam int OFFSET_WIDTH_DEFAULT = 24;
   localparam int CSR_WIDTH            = 24;
   localparam int WORD_WIDTH           = 32;
   localparam int DOFS_WIDTH           = 24;
   localparam logic [CSR_WIDTH-1:0] STRUCT_BYTES_RESET = '1;

   localparam logic [WORD_WIDTH-1:0] TOK_BEGIN_NODE = 32'd1;
   localparam logic [WORD_WIDTH-1:0] TOK_END_NODE   = 32'd2;
   localparam logic [WORD_WIDTH-1:0] TOK_PROP       = 32'd3;
   localparam logic [WORD_WIDTH-1:0] TOK_NOP        = 32'd4;
   localparam logic [WORD_WIDTH-1:0] TOK_END        = 32'd9;

   typedef enum logic [2:0] {
      KIND_BEGIN   = 3'd0,
      KIND_ENDNODE = 3'd1,
      KIND_PROP    = 3'd2,
      KIND_NOP     = 3'd3,
      KIND_END     = 3'd4,
      KIND_ERR     = 3'd5
   } token_kind_type;

   typedef enum logic [2:0] {
      PH_TOKEN   = 3'd0,
      PH_NAME    = 3'd1,
      PH_PLEN    = 3'd2,
      PH_NAMEOFF = 3'd3,
      PH_SKIP    = 3'd4
   } phase_type;

   typedef struct packed {
      logic [WORD_WIDTH-1:0] word;
      logic                  first;
   } item_type;

   typedef struct packed {
      token_kind_type        token_kind;
      logic [WORD_WIDTH-1:0] name_ref;
      logic [WORD_WIDTH-1:0] data_len;
      logic [DOFS_WIDTH-1:0] data_offset;
   } result_type;

   typedef struct packed {
      logic load;
      logic has_result;
   } out_ctl_type;

endpackage

FILE: hdl/fdt_if.sv
// Valid/ready channel interfaces for structure words and parse results.
interface fdt_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] word;
   logic        first;

   modport source (output valid, output word, output first, input ready);
   modport sink   (input valid, input word, input first, output ready);
endinterface

interface fdt_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  token_kind;
   logic [31:0] name_ref;
   logic [31:0] data_len;
   logic [23:0] data_offset;

   modport source (output valid, output token_kind, output name_ref, output data_len,
                   output data_offset, input ready);
   modport sink   (input valid, input token_kind, input name_ref, input data_len,
                   input data_offset, output ready);
endinterface

FILE: hdl/fdt_in_reg.sv
// Input register stage: holds one accepted structure word.
module fdt_in_reg (
   input  logic             clock,
   input  logic             reset,
   fdt_req_if.sink          req_ch,
   input  logic             can_take,
   output logic             issue,
   output fdt_pkg::item_type item
);
   import fdt_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign issue        = valid_ff && can_take;
   assign req_ch.ready = !valid_ff || can_take;
   assign item         = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ch.ready) begin
         valid_in = req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         item_ff <= '{word: req_ch.word, first: req_ch.first};
      end
   end

endmodule

FILE: hdl/fdt_parse_core.sv
// Token parse state machine, offset tracking and result formation.
module fdt_parse_core #(
   parameter int OFFSET_WIDTH = fdt_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [fdt_pkg::CSR_WIDTH-1:0]   csr_write_data,
   input  logic                            issue,
   input  fdt_pkg::item_type               item,
   output fdt_pkg::out_ctl_type            out_ctl,
   output fdt_pkg::result_type             result
);
   import fdt_pkg::*;

   localparam int CW = (OFFSET_WIDTH > CSR_WIDTH) ? OFFSET_WIDTH : CSR_WIDTH;

   logic [CSR_WIDTH-1:0]    struct_bytes_ff;
   phase_type               phase_ff, phase_in;
   logic [OFFSET_WIDTH-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_WIDTH-1:0] name_start_ff, name_start_in;
   logic [OFFSET_WIDTH-1:0] name_length_ff, name_length_in;
   logic [WORD_WIDTH-1:0]   prop_length_ff, prop_length_in;
   logic [CSR_WIDTH-1:0]    skip_words_ff, skip_words_in;
   logic                    halted_ff, halted_in;

   logic [OFFSET_WIDTH-1:0] cur_offset;
   phase_type               cur_phase;
   logic                    cur_halted;
   logic                    work;
   logic [OFFSET_WIDTH-1:0] offset_next;
   logic [CW-1:0]           offset_ext;
   logic [CW-1:0]           offset_next_ext;
   logic [3:0]              byte_zero;
   logic                    name_done;
   logic [1:0]              zero_idx;
   logic [OFFSET_WIDTH-1:0] name_len_end;
   logic [WORD_WIDTH-2:0]   prop_words;
   logic [CSR_WIDTH-1:0]    skip_sat;
   logic [CSR_WIDTH-1:0]    skip_dec;
   logic                    emit;

   assign cur_offset      = item.first ? '0 : byte_offset_ff;
   assign cur_phase       = item.first ? PH_TOKEN : phase_ff;
   assign cur_halted      = item.first ? 1'b0 : halted_ff;
   assign offset_ext      = CW'(cur_offset);
   assign work            = !cur_halted && (offset_ext < CW'(struct_bytes_ff));
   assign offset_next     = cur_offset + OFFSET_WIDTH'(4);
   assign offset_next_ext = CW'(offset_next);

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         byte_zero[i] = (item.word[31-8*i -: 8] == 8'h00);
      end
   end

   always_comb begin
      name_done = 1'b1;
      zero_idx  = 2'd0;
      if (byte_zero[0]) begin
         zero_idx = 2'd0;
      end else if (byte_zero[1]) begin
         zero_idx = 2'd1;
      end else if (byte_zero[2]) begin
         zero_idx = 2'd2;
      end else if (byte_zero[3]) begin
         zero_idx = 2'd3;
      end else begin
         name_done = 1'b0;
      end
   end

   assign name_len_end = name_length_ff + OFFSET_WIDTH'(zero_idx);
   assign prop_words   = prop_length_ff[WORD_WIDTH-1:2]
                         + (WORD_WIDTH-1)'(|prop_length_ff[1:0]);
   assign skip_sat     = (prop_words > (WORD_WIDTH-1)'(struct_bytes_ff))
                         ? struct_bytes_ff : prop_words[CSR_WIDTH-1:0];
   assign skip_dec     = (skip_words_ff != '0) ? skip_words_ff - CSR_WIDTH'(1) : '0;

   // next phase
   always_comb begin
      phase_in = cur_phase;
      if (work) begin
         case (cur_phase)
            PH_NAME: begin
               phase_in = name_done ? PH_TOKEN : PH_NAME;
            end
            PH_PLEN: begin
               phase_in = PH_NAMEOFF;
            end
            PH_NAMEOFF: begin
               phase_in = (skip_sat != '0) ? PH_SKIP : PH_TOKEN;
            end
            PH_SKIP: begin
               phase_in = (skip_dec == '0) ? PH_TOKEN : PH_SKIP;
            end
            default: begin
               if (item.word == TOK_BEGIN_NODE) begin
                  phase_in = PH_NAME;
               end else if (item.word == TOK_PROP) begin
                  phase_in = PH_PLEN;
               end else begin
                  phase_in = PH_TOKEN;
               end
            end
         endcase
      end
   end

   // datapath and result
   always_comb begin
      byte_offset_in = work ? offset_next : cur_offset;
      name_start_in  = name_start_ff;
      name_length_in = name_length_ff;
      prop_length_in = prop_length_ff;
      skip_words_in  = skip_words_ff;
      halted_in      = cur_halted;
      emit           = 1'b0;
      result         = '{token_kind: KIND_NOP, name_ref: '0, data_len: '0, data_offset: '0};
      if (work) begin
         case (cur_phase)
            PH_NAME: begin
               if (name_done) begin
                  name_length_in    = name_len_end;
                  emit              = 1'b1;
                  result.token_kind = KIND_BEGIN;
                  result.name_ref   = WORD_WIDTH'(name_start_ff);
                  result.data_len   = WORD_WIDTH'(name_len_end);
               end else begin
                  name_length_in = name_length_ff + OFFSET_WIDTH'(4);
               end
            end
            PH_PLEN: begin
               prop_length_in = item.word;
            end
            PH_NAMEOFF: begin
               emit               = 1'b1;
               result.token_kind  = KIND_PROP;
               result.name_ref    = item.word;
               result.data_len    = prop_length_ff;
               result.data_offset = offset_next_ext[DOFS_WIDTH-1:0];
               skip_words_in      = skip_sat;
            end
            PH_SKIP: begin
               skip_words_in = skip_dec;
            end
            default: begin
               if (item.word == TOK_BEGIN_NODE) begin
                  name_start_in  = offset_next;
                  name_length_in = '0;
               end else if (item.word == TOK_END_NODE) begin
                  emit              = 1'b1;
                  result.token_kind = KIND_ENDNODE;
               end else if (item.word == TOK_PROP) begin
                  emit = 1'b0;
               end else if (item.word == TOK_NOP) begin
                  emit              = 1'b1;
                  result.token_kind = KIND_NOP;
               end else if (item.word == TOK_END) begin
                  emit              = 1'b1;
                  result.token_kind = KIND_END;
               end else begin
                  emit              = 1'b1;
                  result.token_kind = KIND_ERR;
                  halted_in         = 1'b1;
               end
            end
         endcase
      end
   end

   assign out_ctl = '{load: issue, has_result: emit};

   always_ff @(posedge clock) begin
      if (reset) begin
         struct_bytes_ff <= STRUCT_BYTES_RESET;
      end else if (csr_write_enable) begin
         struct_bytes_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_TOKEN;
         byte_offset_ff <= '0;
         name_start_ff  <= '0;
         name_length_ff <= '0;
         prop_length_ff <= '0;
         skip_words_ff  <= '0;
         halted_ff      <= 1'b0;
      end else if (issue) begin
         phase_ff       <= phase_in;
         byte_offset_ff <= byte_offset_in;
         name_start_ff  <= name_start_in;
         name_length_ff <= name_length_in;
         prop_length_ff <= prop_length_in;
         skip_words_ff  <= skip_words_in;
         halted_ff      <= halted_in;
      end
   end

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      (issue && halted_ff && !item.first) |-> !emit)
      else $error("halted parser produced a result");

   a_err_halts: assert property (@(posedge clock) disable iff (reset)
      (issue && emit && result.token_kind == KIND_ERR) |=> halted_ff)
      else $error("unknown token did not halt the parser");

   a_skip_count: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_SKIP) |-> (skip_words_ff != '0))
      else $error("skip phase with empty skip count");

   a_offset_aligned: assert property (@(posedge clock) disable iff (reset)
      byte_offset_ff[1:0] == 2'b00)
      else $error("byte offset lost word alignment");

endmodule

FILE: hdl/fdt_out_reg.sv
// Result register stage: holds one result until the receiver takes it.
module fdt_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  fdt_pkg::out_ctl_type out_ctl,
   input  fdt_pkg::result_type  result,
   output logic                 can_take,
   fdt_rsp_if.source            rsp_ch
);
   import fdt_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_take           = !valid_ff || rsp_ch.ready;
   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.token_kind  = result_ff.token_kind;
   assign rsp_ch.name_ref    = result_ff.name_ref;
   assign rsp_ch.data_len    = result_ff.data_len;
   assign rsp_ch.data_offset = result_ff.data_offset;

   always_comb begin
      valid_in = valid_ff;
      if (out_ctl.load) begin
         valid_in = out_ctl.has_result;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ctl.load && out_ctl.has_result) begin
         result_ff <= result;
      end
   end

endmodule

FILE: hdl/fdt_struct_token_parser.sv
// Top level of the device tree structure block token parser.
//
// req_ch carries one 32-bit big-endian structure word per transfer, with
// first marking the block's first word (restarts offset, phase and halt).
// rsp_ch carries at most one token result per word: kind, name reference,
// length and data offset. csr_write_enable/csr_write_data set the structure
// size in bytes; words at or past it are dropped silently.
//
// Throughput is one word per cycle while the receiver takes results. A word
// transferred into the input register is decoded there, and its result is
// loaded into the result register when that word issues. The loop through
// the phase and offset registers sets that rate.
//
// Reset clears both stages, parse state returns to expect-token at offset 0
// and the size register goes to all ones. When the receiver stalls, the
// result register holds its transfer and the input register still takes one
// more word; after that req_ch.ready drops until rsp_ch.ready returns.
module fdt_struct_token_parser #(
   parameter int OFFSET_WIDTH = fdt_pkg::OFFSET_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   fdt_req_if.sink                       req_ch,
   fdt_rsp_if.source                     rsp_ch,
   input  logic                          csr_write_enable,
   input  logic [fdt_pkg::CSR_WIDTH-1:0] csr_write_data
);
   import fdt_pkg::*;

   logic        can_take;
   logic        issue;
   item_type    item;
   out_ctl_type out_ctl;
   result_type  result;

   fdt_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .can_take (can_take),
      .issue    (issue),
      .item     (item)
   );

   fdt_parse_core #(
      .OFFSET_WIDTH (OFFSET_WIDTH)
   ) u_parse_core (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .issue            (issue),
      .item             (item),
      .out_ctl          (out_ctl),
      .result           (result)
   );

   fdt_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .out_ctl  (out_ctl),
      .result   (result),
      .can_take (can_take),
      .rsp_ch   (rsp_ch)
   );

endmodule
